// ----- rtl/core/moc_pkg.sv -----
package moc_pkg;

    // Field widths of the request and result transactions.
    localparam int POT_W  = 15;
    localparam int OFS_W  = 11;
    localparam int LIM_W  = 10;
    localparam int ELEC_W = 3;

    // Request kinds.
    localparam logic REQ_RECORD  = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // Reset value of the offset limit register.
    localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd320;

    typedef logic [POT_W-1:0]         t_pot;
    typedef logic signed [OFS_W-1:0]  t_ofs;
    typedef logic [LIM_W-1:0]         t_lim;
    typedef logic [ELEC_W-1:0]        t_elec;

endpackage

// ----- rtl/core/moc_req_if.sv -----
interface moc_req_if
    import moc_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  req_type;
    t_elec electrode;
    t_pot  potential;
    logic  store;

    modport source (output valid, output req_type, output electrode, output potential,
                    output store, input ready);
    modport sink   (input valid, input req_type, input electrode, input potential,
                    input store, output ready);
endinterface

// ----- rtl/core/moc_res_if.sv -----
interface moc_res_if
    import moc_pkg::*;
();
    logic  valid;
    logic  ready;
    t_elec out_electrode;
    t_ofs  offset;
    t_pot  median;
    logic  median_valid;
    logic  last;

    modport source (output valid, output out_electrode, output offset, output median,
                    output median_valid, output last, input ready);
    modport sink   (input valid, input out_electrode, input offset, input median,
                    input median_valid, input last, output ready);
endinterface

// ----- rtl/core/median_offset_calibration_unit.sv -----
// Channel   | Direction | Handshake     | Payload
// i_req     | in        | valid/ready   | req_type, electrode, potential, store
// o_res     | out       | valid/ready   | out_electrode, offset, median, median_valid, last
// i_cfg     | in        | write enable  | offset_limit (10 bit)
//
// A record transaction writes the potential store while the block is idle. A compute
// transaction counts the stored potentials, finds their median, updates the offsets if
// store is set and then emits one result per electrode, holding on any output stall;
// empty electrodes are skipped in the ranking: one shared comparator ranks every stored
// potential against every other over the single read port of the potential store.
// The reset is synchronous and clears the stores and the median, and restores the limit.
// While the result register waits for o_res.ready the sequencer holds.
module median_offset_calibration_unit
    import moc_pkg::*;
#(
    parameter int ELECTRODES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    moc_req_if.sink   i_req,
    moc_res_if.source o_res,
    input  logic      i_cfg_we,
    input  t_lim      i_cfg_wdata
);

    localparam int IW = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;
    localparam int CW = $clog2(ELECTRODES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ELECTRODES - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COUNT  = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_MEDIAN = 3'd4;
    localparam logic [2:0] S_PREP   = 3'd5;
    localparam logic [2:0] S_WAIT   = 3'd6;

    logic [2:0]    r_state;
    t_pot          r_pot [ELECTRODES];
    t_ofs          r_ofs [ELECTRODES];
    t_pot          r_median;
    logic          r_valid;
    t_lim          r_limit;
    logic          r_apply;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_lt;
    logic [CW-1:0] r_le;
    t_pot          r_cand;
    t_pot          r_m1;
    t_pot          r_m2;
    t_elec         r_out_elec;
    t_ofs          r_out_ofs;
    logic          r_out_last;

    logic [IW-1:0]        rd_idx;
    t_pot                 rd_pot;
    logic                 rd_nz;
    logic                 cmp_lt;
    logic                 cmp_le;
    logic [CW-1:0]        lt_nx;
    logic [CW-1:0]        le_nx;
    logic [CW-1:0]        half;
    logic [POT_W:0]       pair_sum;
    logic signed [16:0]   upd_sum;
    logic signed [16:0]   upd_mag;
    t_ofs                 upd_ofs;

    // Single read port of the potential store, steered by the sequencer.
    always_comb begin
        unique case (r_state)
            S_COUNT, S_SCAN: rd_idx = r_j;
            default:         rd_idx = r_i;
        endcase
    end
    assign rd_pot = r_pot[rd_idx];
    assign rd_nz  = (rd_pot != '0);

    // Shared comparator and rank counters.
    assign cmp_lt = (rd_pot < r_cand);
    assign cmp_le = (rd_pot <= r_cand);
    assign lt_nx  = r_lt + CW'(rd_nz && cmp_lt);
    assign le_nx  = r_le + CW'(rd_nz && cmp_le);
    assign half   = r_cnt >> 1;

    // Mean of the two middle values, rounded down.
    assign pair_sum = {1'b0, r_m1} + {1'b0, r_m2};

    // Offset update of one electrode, with the true magnitude checked.
    always_comb begin
        upd_sum = $signed({{6{r_ofs[r_i][OFS_W-1]}}, r_ofs[r_i]})
                + $signed({2'b00, r_median}) - $signed({2'b00, rd_pot});
        upd_mag = upd_sum[16] ? -upd_sum : upd_sum;
        if (upd_mag > $signed({7'd0, r_limit})) begin
            upd_ofs = '0;
        end else begin
            upd_ofs = upd_sum[OFS_W-1:0];
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Sequencer and stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_median <= '0;
            r_valid  <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_cnt    <= '0;
            r_lt     <= '0;
            r_le     <= '0;
            for (int k = 0; k < ELECTRODES; k++) begin
                r_pot[k] <= '0;
                r_ofs[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.req_type == REQ_RECORD) begin
                            if (32'(i_req.electrode) < ELECTRODES) begin
                                r_pot[IW'(i_req.electrode)] <= i_req.potential;
                            end
                        end else begin
                            r_apply <= i_req.store;
                            r_j     <= '0;
                            r_cnt   <= '0;
                            r_state <= S_COUNT;
                        end
                    end
                end
                S_COUNT: begin
                    r_cnt <= r_cnt + CW'(rd_nz);
                    if (r_j == LAST_IDX) begin
                        r_i     <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_LOAD: begin
                    // Fetch the next candidate; empty entries are skipped.
                    r_cand <= rd_pot;
                    r_j    <= '0;
                    r_lt   <= '0;
                    r_le   <= '0;
                    if (rd_nz) begin
                        r_state <= S_SCAN;
                    end else if (r_i == LAST_IDX) begin
                        r_state <= S_MEDIAN;
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                S_SCAN: begin
                    r_lt <= lt_nx;
                    r_le <= le_nx;
                    if (r_j == LAST_IDX) begin
                        // The candidate holds rank k when lt <= k < le.
                        if (lt_nx < half && half <= le_nx) begin
                            r_m1 <= r_cand;
                        end
                        if (lt_nx <= half && half < le_nx) begin
                            r_m2 <= r_cand;
                        end
                        if (r_i == LAST_IDX) begin
                            r_state <= S_MEDIAN;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_MEDIAN: begin
                    r_valid <= (r_cnt != '0);
                    if (r_cnt != '0) begin
                        r_median <= r_cnt[0] ? r_m2 : pair_sum[POT_W:1];
                    end
                    r_i     <= '0;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    // Update one offset and load the result register.
                    r_out_elec <= ELEC_W'(r_i);
                    r_out_last <= (r_i == LAST_IDX);
                    if (r_apply && r_valid && rd_nz) begin
                        r_ofs[r_i] <= upd_ofs;
                        r_out_ofs  <= upd_ofs;
                    end else begin
                        r_out_ofs  <= r_ofs[r_i];
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (o_res.ready) begin
                        if (r_i == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_PREP;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_res.valid         = (r_state == S_WAIT);
    assign o_res.out_electrode = r_out_elec;
    assign o_res.offset        = r_out_ofs;
    assign o_res.median        = r_median;
    assign o_res.median_valid  = r_valid;
    assign o_res.last          = r_out_last;

`ifndef SYNTH
    // A result is never offered while a new request can be taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready)
        else $error("result offered while accepting requests");

    // The nonzero count never exceeds the number of electrodes.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= ELECTRODES)
        else $error("nonzero count out of range");

    // The last result of a run returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last) |=> i_req.ready)
        else $error("block not idle after last result");

    // A compute request leads straight into the counting pass.
    a_compute_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.req_type == REQ_COMPUTE)
        |=> (r_state == S_COUNT && r_cnt == '0))
        else $error("compute request did not start counting");
`endif

endmodule

// ----- dv/testbench.sv -----
module testbench;
    import moc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELECTRODES     = 8;
    localparam int SETTLE_CYCLES  = 120;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // One request transaction as the sender presents it.
    typedef struct packed {
        logic  kind;
        t_elec electrode;
        t_pot  potential;
        logic  store;
    } request_t;

    // One per-electrode report as the block should emit it.
    typedef struct packed {
        t_elec electrode;
        t_ofs  offset;
        t_pot  median;
        logic  median_ok;
        logic  last;
    } report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_lim cfg_wdata;

    moc_req_if req_if();
    moc_res_if res_if();

    median_offset_calibration_unit #(
        .ELECTRODES (ELECTRODES)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #2ns clk = ~clk;

    // Shadow copy of the calibration state.
    t_pot pot_mem [ELECTRODES];
    t_ofs ofs_mem [ELECTRODES];
    t_pot median_hold;
    t_lim limit_reg;

    request_t request_q [$];
    report_t  report_q  [$];
    request_t on_bus;

    int n_queued      = 0;
    int n_accepted    = 0;
    int errors        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    bit long_hold_armed = 1'b0;
    bit long_hold_done  = 1'b0;

    // Applies one accepted request to the shadow state and queues the reports it causes.
    task automatic apply_request(input request_t r);
        t_pot    ranked [ELECTRODES];
        int      cnt;
        int      j;
        int      h;
        int      sum;
        int      mag;
        bit      med_ok;
        report_t rep;
        if (r.kind == REQ_RECORD) begin
            pot_mem[r.electrode] = r.potential;
            return;
        end
        // Insertion sort of the electrodes that hold a potential.
        cnt = 0;
        for (int i = 0; i < ELECTRODES; i++) begin
            if (pot_mem[i] != '0) begin
                j = cnt;
                while (j > 0 && ranked[j-1] > pot_mem[i]) begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = pot_mem[i];
                cnt++;
            end
        end
        med_ok = (cnt > 0);
        if (med_ok) begin
            h = cnt / 2;
            if (cnt % 2 == 1) begin
                median_hold = ranked[h];
            end else begin
                median_hold = t_pot'((int'(ranked[h-1]) + int'(ranked[h])) >> 1);
            end
            // Offsets move towards the median; an excessive one is cleared.
            if (r.store) begin
                for (int i = 0; i < ELECTRODES; i++) begin
                    if (pot_mem[i] != '0) begin
                        sum = int'(ofs_mem[i]) + int'(median_hold) - int'(pot_mem[i]);
                        mag = (sum < 0) ? -sum : sum;
                        if (mag > int'(limit_reg)) begin
                            sum = 0;
                        end
                        ofs_mem[i] = t_ofs'(sum);
                    end
                end
            end
        end
        for (int i = 0; i < ELECTRODES; i++) begin
            rep.electrode = t_elec'(i);
            rep.offset    = ofs_mem[i];
            rep.median    = median_hold;
            rep.median_ok = med_ok;
            rep.last      = (i == ELECTRODES - 1);
            report_q.push_back(rep);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic push(input request_t r);
        request_q.push_back(r);
        n_queued++;
    endtask

    // A record transaction; the store bit is unused and left random.
    task automatic push_record(input int e, input int p);
        request_t r;
        r.kind      = REQ_RECORD;
        r.electrode = t_elec'(e);
        r.potential = t_pot'(p);
        r.store     = 1'($urandom_range(1));
        push(r);
    endtask

    // A compute transaction; electrode and potential are unused and left random.
    task automatic push_compute(input bit s);
        request_t r;
        r.kind      = REQ_COMPUTE;
        r.electrode = t_elec'($urandom_range(7));
        r.potential = t_pot'($urandom_range(32767));
        r.store     = s;
        push(r);
    endtask

    // Mostly records clustered round a base so that offsets survive, with rare computes
    // and some records over the full range or clearing an electrode.
    task automatic push_random(input int n, input int base);
        int roll;
        int p;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 13) begin
                push_compute(1'($urandom_range(3) != 0));
            end else if (roll < 85) begin
                p = base + $urandom_range(600) - 300;
                if ($urandom_range(9) == 0) begin
                    p = 0;
                end
                push_record($urandom_range(7), p);
            end else begin
                push_record($urandom_range(7), $urandom_range(32767));
            end
        end
    endtask

    // Waits until every request is taken and every report has arrived, then lets the
    // block settle.
    task automatic drain();
        while (n_accepted != n_queued || report_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= t_lim'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_reg = t_lim'(v);
    endtask

    // Request driver: holds a transaction until it is taken, idles at random.
    always @(posedge clk) begin : driver
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_request(on_bus);
                n_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = request_q.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.req_type  <= on_bus.kind;
                    req_if.electrode <= on_bus.electrode;
                    req_if.potential <= on_bus.potential;
                    req_if.store     <= on_bus.store;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor: compares each transaction with the oldest expected report and
    // stalls the block at random or for one long stretch.
    always @(posedge clk) begin : monitor
        report_t want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (report_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected report, expected none, actual electrode %0d offset %0d",
                             $time, res_if.out_electrode, res_if.offset);
                end else begin
                    want = report_q.pop_front();
                    check_field("out_electrode", int'(want.electrode), int'(res_if.out_electrode));
                    check_field("offset", int'(want.offset), int'(res_if.offset));
                    check_field("median", int'(want.median), int'(res_if.median));
                    check_field("median_valid", int'(want.median_ok), int'(res_if.median_valid));
                    check_field("last", int'(want.last), int'(res_if.last));
                end
            end
            if (long_hold_armed && !long_hold_done) begin
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD;
                res_if.ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_RECORD;
        req_if.electrode = '0;
        req_if.potential = '0;
        req_if.store     = 1'b0;
        res_if.ready     = 1'b0;
        limit_reg        = LIMIT_RESET;
        median_hold      = '0;
        for (int i = 0; i < ELECTRODES; i++) begin
            pot_mem[i] = '0;
            ofs_mem[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // First phase: the sender idles rarely, the receiver often.
        send_idle_pct = 11;
        recv_idle_pct = 46;

        // Computes with nothing recorded, with and without the store flag.
        push_compute(1'b1);
        push_compute(1'b0);
        // Extreme potentials: an even pair whose offsets overshoot the limit.
        push_record(0, 32767);
        push_record(7, 1);
        push_compute(1'b1);
        // Close potentials, odd count, then a report-only compute and accumulation.
        push_record(0, 1000);
        push_record(7, 1010);
        push_record(3, 1020);
        push_compute(1'b1);
        push_compute(1'b0);
        push_compute(1'b1);
        // Clearing an electrode keeps its offset frozen.
        push_record(3, 0);
        push_compute(1'b1);
        // Every electrode filled, even count.
        push_record(1, 1100);
        push_record(2, 700);
        push_record(4, 1005);
        push_record(5, 990);
        push_record(6, 1300);
        push_record(3, 1015);
        push_compute(1'b1);
        push_compute(1'b1);
        drain();

        // Widest limit: offsets near both ends of their range.
        write_limit(1023);
        push_record(2, 1);
        push_record(6, 2020);
        push_compute(1'b1);
        push_compute(1'b1);
        push_random(95, $urandom_range(1000, 31000));
        drain();

        // Second phase: idling roles swapped; a zero limit clears every updated offset.
        send_idle_pct = 46;
        recv_idle_pct = 11;
        write_limit(0);
        push_random(15, $urandom_range(1000, 31000));
        push_compute(1'b1);
        drain();
        write_limit($urandom_range(1, 1022));
        push_random(100, $urandom_range(1000, 31000));
        drain();

        // Last phase: no idling, but one long receiver hold while requests keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit($urandom_range(1, 1022));
        long_hold_armed = 1'b1;
        push_random(100, $urandom_range(1000, 31000));
        drain();

        if (errors == 0 && report_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
